### rtl/sitda_pkg.sv
// ============================================================================
// sitda_pkg
// Shared types and constants for the signed integer to decimal text block.
// ============================================================================
package sitda_pkg;

    // Width of the incoming two's complement integer.
    localparam int VALUE_BITS = 32;

    // Decimal digits needed for the largest magnitude, 2^(VALUE_BITS-1).
    // 1233/4096 approximates log10(2) closely enough up to 64 bits.
    localparam int NUM_DIGITS = ((VALUE_BITS - 1) * 1233) / 4096 + 1;

    localparam int BIT_CNT_W = $clog2(VALUE_BITS);
    localparam int REM_W     = $clog2(NUM_DIGITS + 1);

    localparam int CHAR_W = 6;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(45);

    typedef logic [3:0] bcd_t;

    // Control shared by every digit cell of the chain.
    typedef struct packed {
        logic clear;     // zero the digit
        logic convert;   // one shift-and-add-3 step
        logic shift_up;  // take the digit of the lower neighbor
    } cell_ctrl_t;

endpackage

### rtl/sitda_digit_cell.sv
// ============================================================================
// sitda_digit_cell
// One BCD digit of the conversion chain: cleared on load, shift-and-add-3
// step during conversion, digit shift toward the top during text output.
// ============================================================================
module sitda_digit_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sitda_pkg::cell_ctrl_t ctrl,
    input  logic                  carry_in,
    input  sitda_pkg::bcd_t       digit_in,
    output sitda_pkg::bcd_t       digit,
    output logic                  carry_out
);

    sitda_pkg::bcd_t digit_reg;
    sitda_pkg::bcd_t digit_next;
    sitda_pkg::bcd_t adj;

    // Correct the digit before doubling so it stays in BCD range.
    assign adj       = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
    assign carry_out = adj[3];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.convert)
        begin
            digit_next = {adj[2:0], carry_in};
        end
        else if (ctrl.shift_up)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

### rtl/signed_int_to_decimal_ascii_top.sv
// ============================================================================
// signed_int_to_decimal_ascii_top
// Converts one signed integer per request into its decimal ASCII text, most
// significant character first, with a leading '-' for negative values.
// ============================================================================
//
//  Channel | Ports                                    | Direction
//  --------+------------------------------------------+-----------
//  value   | value_valid, value_ready, value          | request in
//  char    | char_valid, char_ready, character, last  | text out
//
//  Sequence: accept, then VALUE_BITS conversion steps through the digit
//  chain (32 at the default width), then the sign of a negative value,
//  then the NUM_DIGITS digit positions from the top, at each of which a
//  leading zero is dropped or one digit is emitted; the magnitude moves
//  bit-serially through the digit cells.
//  Reset: rst_n clears the controller and the output register at once.
//  Stalls: a low char_ready holds the sign and digit output; one request is
//  in work at a time, and value_ready is high only while the controller is
//  idle.
// ============================================================================
module signed_int_to_decimal_ascii_top
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    value_valid,
    output logic                                    value_ready,
    input  logic signed [sitda_pkg::VALUE_BITS-1:0] value,
    output logic                                    char_valid,
    input  logic                                    char_ready,
    output logic [sitda_pkg::CHAR_W-1:0]            character,
    output logic                                    last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_EMIT
    } state_t;

    state_t                              state_reg;
    logic [sitda_pkg::VALUE_BITS-1:0]    mag_reg;
    logic                                neg_reg;
    logic                                sign_pend_reg;
    logic                                lead_zero_reg;
    logic [sitda_pkg::BIT_CNT_W-1:0]     bit_cnt_reg;
    logic [sitda_pkg::REM_W-1:0]         rem_reg;
    logic                                out_valid_reg;
    logic [sitda_pkg::CHAR_W-1:0]        char_reg;
    logic                                last_reg;

    sitda_pkg::cell_ctrl_t               ctrl;
    sitda_pkg::bcd_t                     digit_w [sitda_pkg::NUM_DIGITS];
    logic                                carry_w [sitda_pkg::NUM_DIGITS];
    sitda_pkg::bcd_t                     top_digit;
    logic                                accept;
    logic                                out_free;
    logic                                skip_zero;
    logic                                load_char;

    assign value_ready = (state_reg == S_IDLE);
    assign accept      = value_valid && value_ready;
    assign out_free    = !out_valid_reg || char_ready;
    assign top_digit   = digit_w[sitda_pkg::NUM_DIGITS-1];
    // Drop a zero only until the first digit goes out, and always keep the
    // final digit.
    assign skip_zero   = lead_zero_reg && (top_digit == '0)
                         && (rem_reg > sitda_pkg::REM_W'(1));
    // The output register takes a new character this cycle.
    assign load_char   = (state_reg == S_EMIT) && out_free
                         && (sign_pend_reg || !skip_zero);

    assign char_valid = out_valid_reg;
    assign character  = char_reg;
    assign last       = last_reg;

    // Chain control: clear on load, double-dabble during conversion, shift
    // toward the top whenever a digit leaves the top cell.
    always_comb
    begin
        ctrl          = '0;
        ctrl.clear    = accept;
        ctrl.convert  = (state_reg == S_CONV);
        ctrl.shift_up = (state_reg == S_EMIT) && !sign_pend_reg
                        && (skip_zero || out_free);
    end

    // Cell 0 holds the least significant digit and takes the magnitude MSB;
    // carries and emitted digits move toward the highest cell.
    for (genvar i = 0; i < sitda_pkg::NUM_DIGITS; i++)
    begin : g_cell
        logic            cin;
        sitda_pkg::bcd_t din;

        if (i == 0)
        begin : g_first
            assign cin = mag_reg[sitda_pkg::VALUE_BITS-1];
            assign din = '0;
        end
        else
        begin : g_rest
            assign cin = carry_w[i-1];
            assign din = digit_w[i-1];
        end

        sitda_digit_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .carry_in  (cin),
            .digit_in  (din),
            .digit     (digit_w[i]),
            .carry_out (carry_w[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mag_reg       <= '0;
            neg_reg       <= 1'b0;
            sign_pend_reg <= 1'b0;
            lead_zero_reg <= 1'b0;
            bit_cnt_reg   <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            // Drop the output once the consumer takes it and nothing new
            // replaces it.
            if (char_ready && !load_char)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        // Negation modulo 2^VALUE_BITS gives the exact
                        // magnitude of the most negative value too.
                        neg_reg     <= value[sitda_pkg::VALUE_BITS-1];
                        mag_reg     <= value[sitda_pkg::VALUE_BITS-1]
                                       ? -value : value;
                        bit_cnt_reg <= '0;
                        state_reg   <= S_CONV;
                    end
                end

                S_CONV:
                begin
                    // Advance one magnitude bit into the chain.
                    mag_reg     <= {mag_reg[sitda_pkg::VALUE_BITS-2:0], 1'b0};
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == sitda_pkg::BIT_CNT_W'(sitda_pkg::VALUE_BITS - 1))
                    begin
                        rem_reg       <= sitda_pkg::REM_W'(sitda_pkg::NUM_DIGITS);
                        sign_pend_reg <= neg_reg;
                        lead_zero_reg <= 1'b1;
                        state_reg     <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (sign_pend_reg)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            char_reg      <= sitda_pkg::CHAR_MINUS;
                            last_reg      <= 1'b0;
                            sign_pend_reg <= 1'b0;
                        end
                    end
                    else if (skip_zero)
                    begin
                        rem_reg <= rem_reg - 1'b1;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        char_reg      <= sitda_pkg::CHAR_ZERO
                                         + {2'b00, top_digit};
                        last_reg      <= (rem_reg == sitda_pkg::REM_W'(1));
                        rem_reg       <= rem_reg - 1'b1;
                        lead_zero_reg <= 1'b0;
                        if (rem_reg == sitda_pkg::REM_W'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // The top digit cell never overflows during conversion.
    a_no_chain_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CONV) |-> !carry_w[sitda_pkg::NUM_DIGITS-1])
        else $error("digit chain overflow");

    // Text output always has a digit left to give.
    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (rem_reg != '0))
        else $error("emit with no digits left");

    // A minus sign is never the last character.
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (char_reg == sitda_pkg::CHAR_MINUS)) |-> !last_reg)
        else $error("minus sign flagged last");

    // The final digit returns the controller to idle.
    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && !sign_pend_reg && !skip_zero && out_free
         && (rem_reg == sitda_pkg::REM_W'(1))) |=> (state_reg == S_IDLE))
        else $error("item did not end after last digit");

endmodule

### bench/tb_signed_int_to_decimal_ascii_top.sv
// ============================================================================
// tb_signed_int_to_decimal_ascii_top
// Self-checking bench for the signed integer to decimal ASCII converter.
// Drives integers as requests, predicts the character stream of each one
// (sign, digits without leading zeros, last flag on the final character)
// and compares every accepted character against the oldest prediction.
// Sender bursts and gaps, receiver stall patterns and one long receiver
// hold-off exercise the handshakes on both sides.
// ============================================================================
module tb_signed_int_to_decimal_ascii_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_HALF_NS     = 10;
    localparam int          RESET_CYCLES    = 6;
    localparam int          RANDOM_REQUESTS = 124;
    localparam int          HOLDOFF_CYCLES  = 400;
    localparam int          DRAIN_CYCLES    = 100;
    localparam int          MAX_REPORTS     = 10;
    localparam int          MAX_GAP         = 40;
    localparam int          MAX_BURST       = 6;
    localparam int          PATTERN_PERIOD  = 700;
    localparam longint     DECIMAL_BASE    = 10;
    localparam longint     RUN_LIMIT_NS    = 5_000_000;

    // One character of the expected decimal text.
    typedef struct packed {
        logic [sitda_pkg::CHAR_W-1:0] character;
        logic                         last;
    } text_char_t;

    // Receiver ready patterns, rotated over time.
    typedef enum logic [1:0] {
        RX_ALWAYS_READY,
        RX_SHORT_STALLS,
        RX_LONG_STALLS
    } rx_pattern_e;

    logic                                    clk;
    logic                                    rst_n;
    logic                                    value_valid;
    logic                                    value_ready;
    logic signed [sitda_pkg::VALUE_BITS-1:0] value;
    logic                                    char_valid;
    logic                                    char_ready;
    logic [sitda_pkg::CHAR_W-1:0]            character;
    logic                                    last;

    // Characters predicted for accepted requests, oldest first.
    text_char_t expected_text_q[$];
    int         mismatch_count;

    // Sender idling: gap_max of zero means back-to-back requests.
    int         sender_gap_max;
    int         sender_burst_left;

    // Bumped by a test to make the receiver hold off for HOLDOFF_CYCLES.
    int         holdoff_ticket;

    signed_int_to_decimal_ascii_top u_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .value       (value),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .character   (character),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // Hard stop in case the block hangs or drops characters.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction: decimal text of one signed integer. The magnitude is taken
    // unsigned at the value width, so the most negative value gives exactly
    // 2^(VALUE_BITS-1). Zero still yields one digit.
    // ------------------------------------------------------------------------
    function automatic void predict_decimal_text(
        input logic signed [sitda_pkg::VALUE_BITS-1:0] v);
        logic [sitda_pkg::VALUE_BITS-1:0] magnitude;
        logic [3:0]                       digits[$];
        text_char_t                       entry;

        magnitude = v;
        if (v[sitda_pkg::VALUE_BITS-1])
        begin
            magnitude = ~magnitude + 1'b1;
        end
        do
        begin
            digits.push_front(4'(magnitude % DECIMAL_BASE));
            magnitude = sitda_pkg::VALUE_BITS'(magnitude / DECIMAL_BASE);
        end
        while (magnitude != 0);

        if (v[sitda_pkg::VALUE_BITS-1])
        begin
            entry.character = sitda_pkg::CHAR_MINUS;
            entry.last      = 1'b0;
            expected_text_q.push_back(entry);
        end
        foreach (digits[i])
        begin
            entry.character = sitda_pkg::CHAR_ZERO + sitda_pkg::CHAR_W'(digits[i]);
            entry.last      = (i == digits.size() - 1);
            expected_text_q.push_back(entry);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Send one request and record its expected text once it is accepted.
    // Valid stays high into the next request when the burst continues, so
    // back-to-back requests never see valid dropped and raised in one step.
    // ------------------------------------------------------------------------
    task automatic send_value(input logic signed [sitda_pkg::VALUE_BITS-1:0] v);
        value_valid <= 1'b1;
        value       <= v;
        do
        begin
            @(posedge clk);
        end
        while (!value_ready);
        predict_decimal_text(v);

        if (sender_gap_max == 0)
        begin
            return;
        end
        if (sender_burst_left > 0)
        begin
            sender_burst_left--;
        end
        else
        begin
            // End of burst: drop valid and idle for a random gap.
            value_valid <= 1'b0;
            repeat ($urandom_range(1, sender_gap_max)) @(posedge clk);
            sender_burst_left = $urandom_range(0, MAX_BURST - 1);
        end
    endtask

    // Drop valid and wait until every predicted character has come out.
    task automatic drain_text;
        value_valid <= 1'b0;
        while (expected_text_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Random integer: mostly a random digit count and sign, so every text
    // length shows up; some fully random bit patterns to toggle every bit.
    function automatic logic signed [sitda_pkg::VALUE_BITS-1:0] random_decimal_value();
        longint low_mag;
        longint high_mag;
        longint cap_mag;
        longint mag;
        int     num_digits;
        bit     negative;

        if ($urandom_range(0, 4) == 0)
        begin
            return $urandom;
        end
        num_digits = $urandom_range(1, 10);
        negative   = 1'($urandom_range(0, 1));
        low_mag    = 1;
        repeat (num_digits - 1) low_mag = low_mag * DECIMAL_BASE;
        high_mag   = low_mag * DECIMAL_BASE - 1;
        if (num_digits == 1)
        begin
            low_mag = 0;
        end
        cap_mag = negative ? 64'd2147483648 : 64'd2147483647;
        if (high_mag > cap_mag)
        begin
            high_mag = cap_mag;
        end
        mag = low_mag + longint'($urandom) % (high_mag - low_mag + 1);
        return sitda_pkg::VALUE_BITS'(negative ? -mag : mag);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Zero, small values, both ends of the range and the most negative value.
    task automatic test_boundary_values;
        logic signed [sitda_pkg::VALUE_BITS-1:0] vals [10] = '{
            32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
            32'sd2147483647, 32'sh8000_0000, -32'sd2147483647
        };

        sender_gap_max = 0;
        foreach (vals[i])
        begin
            send_value(vals[i]);
        end
        drain_text();
    endtask

    // Values where the digit count changes, with random sender gaps.
    task automatic test_digit_count_edges;
        logic signed [sitda_pkg::VALUE_BITS-1:0] vals [10] = '{
            32'sd99, 32'sd100, -32'sd999, 32'sd1000, 32'sd99999,
            -32'sd100000, 32'sd9999999, -32'sd10000000,
            32'sd999999999, -32'sd1000000000
        };

        sender_gap_max = MAX_GAP;
        foreach (vals[i])
        begin
            send_value(vals[i]);
        end
        drain_text();
    endtask

    // Receiver holds off for a long stretch while requests keep coming,
    // so output backs up and the block stops taking requests.
    task automatic test_receiver_holdoff;
        sender_gap_max = 0;
        holdoff_ticket <= holdoff_ticket + 1;
        repeat (6) send_value(random_decimal_value());
        drain_text();
    endtask

    // Random requests: first a stretch with no sender gaps, then bursts.
    task automatic test_random_values;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            sender_gap_max = (n < RANDOM_REQUESTS / 3) ? 0 : MAX_GAP;
            send_value(random_decimal_value());
        end
        drain_text();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: check each accepted character against the oldest prediction,
    // then pick char_ready for the next edge from the current pattern.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input text_char_t want,
                                   input text_char_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t: %s: expected char %0d last %0b, got char %0d last %0b",
                     $realtime, what, want.character, want.last,
                     got.character, got.last);
        end
    endtask

    initial
    begin : text_receiver
        text_char_t  got;
        text_char_t  want;
        rx_pattern_e pattern;
        int          stall_left;
        int          holdoff_left;
        int          served_ticket;
        int          cycle_idx;

        stall_left    = 0;
        holdoff_left  = 0;
        served_ticket = 0;
        cycle_idx     = 0;
        char_ready   <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && char_valid && char_ready)
            begin
                got.character = character;
                got.last      = last;
                if (expected_text_q.size() == 0)
                begin
                    want = '0;
                    report_mismatch("unexpected character", want, got);
                end
                else
                begin
                    want = expected_text_q.pop_front();
                    if (got.character !== want.character)
                    begin
                        report_mismatch("character mismatch", want, got);
                    end
                    else if (got.last !== want.last)
                    begin
                        report_mismatch("last flag mismatch", want, got);
                    end
                end
            end

            // Start a requested hold-off; it is counted here, not by the test.
            if (holdoff_ticket != served_ticket)
            begin
                served_ticket = holdoff_ticket;
                holdoff_left  = HOLDOFF_CYCLES;
            end

            pattern = rx_pattern_e'((cycle_idx / PATTERN_PERIOD) % 3);
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                char_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                char_ready <= 1'b0;
            end
            else
            begin
                char_ready <= 1'b1;
                case (pattern)
                    RX_SHORT_STALLS:
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            stall_left = $urandom_range(1, 3);
                        end
                    end
                    RX_LONG_STALLS:
                    begin
                        if ($urandom_range(0, 9) == 0)
                        begin
                            stall_left = $urandom_range(4, 12);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            cycle_idx++;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: reset once, run each test, let the pipe settle, report.
    // ------------------------------------------------------------------------
    initial
    begin
        mismatch_count    = 0;
        sender_gap_max    = 0;
        sender_burst_left = 0;
        holdoff_ticket    = 0;
        rst_n            <= 1'b0;
        value_valid      <= 1'b0;
        value            <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_boundary_values();
        test_digit_count_edges();
        test_receiver_holdoff();
        test_random_values();

        // Catch any stray characters after the last expected one.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_text_q.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
